// ===== sv/djq_pkg.sv =====
package djq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int NUM_HANDLES_DEF = 1024;

  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 10;
  localparam int LIMIT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_DONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_GET_CHK,
    ST_PURGE,
    ST_RESP
  } state_t;

  // datapath operation selected by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_EXEC,
    OP_CHK,
    OP_PURGE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;       // latch the request payload
    logic emit;       // load result register from live result
    logic emit_held;  // load result register from held result
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic get_hit;     // get on a non-empty queue
    logic remove_go;   // remove of a busy handle
    logic purge_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/djq_in_if.sv =====
interface djq_in_if;
  import djq_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HANDLE_W-1:0] handle;
  logic                remove_on_get;

  modport source(output valid, func, handle, remove_on_get, input ready);
  modport sink(input valid, func, handle, remove_on_get, output ready);
endinterface

// ===== sv/djq_out_if.sv =====
interface djq_out_if;
  import djq_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] job_handle;

  modport source(output valid, ok, job_handle, input ready);
  modport sink(input valid, ok, job_handle, output ready);
endinterface

// ===== sv/djq_ctrl.sv =====
module djq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  djq_pkg::dp_stat_t stat,
  output djq_pkg::dp_cmd_t  cmd
);
  import djq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.get_hit) state_next = ST_GET_CHK;
        else if (stat.remove_go) state_next = ST_PURGE;
        else if (stat.out_free) state_next = ST_IDLE;
        else state_next = ST_RESP;
      end
      ST_GET_CHK: begin
        state_next = stat.out_free ? ST_IDLE : ST_RESP;
      end
      ST_PURGE: begin
        if (stat.purge_done) state_next = stat.out_free ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.load      = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_held = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.op   = OP_EXEC;
        cmd.emit = !stat.get_hit && !stat.remove_go && stat.out_free;
      end
      ST_GET_CHK: begin
        cmd.op   = OP_CHK;
        cmd.emit = stat.out_free;
      end
      ST_PURGE: begin
        cmd.op        = OP_PURGE;
        cmd.emit_held = stat.purge_done && stat.out_free;
      end
      ST_RESP: begin
        cmd.emit_held = stat.out_free;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.emit_held))
    else $error("both result sources selected");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> $past(in_valid && in_ready))
    else $error("execute step without an accepted transaction");

  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (state == ST_CLEAR || state == ST_IDLE))
    else $error("left bitmap clear sweep to a working state");
`endif

endmodule

// ===== sv/djq_datapath.sv =====
module djq_datapath #(
  parameter int QUEUE_DEPTH = djq_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_HANDLES = djq_pkg::NUM_HANDLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  djq_pkg::dp_cmd_t              cmd,
  output djq_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [djq_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic [djq_pkg::FUNC_W-1:0]    req_func,
  input  logic [djq_pkg::HANDLE_W-1:0]  req_handle,
  input  logic                          req_rm,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          rsp_ok,
  output logic [djq_pkg::HANDLE_W-1:0]  rsp_job
);
  import djq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int HIDX_W = $clog2(NUM_HANDLES);
  localparam int EXT_W  = ((HIDX_W > HANDLE_W) ? HIDX_W : HANDLE_W) + 1;
  localparam int LIM_W  = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

  function automatic logic [PTR_W-1:0] slot_of(logic [PTR_W-1:0] base,
                                               logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) sum = sum - SUM_W'(QUEUE_DEPTH);
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [HIDX_W-1:0] to_idx(logic [HANDLE_W-1:0] h);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(h);
    return ext[HIDX_W-1:0];
  endfunction

  function automatic logic in_range(logic [HANDLE_W-1:0] h);
    return EXT_W'(h) < EXT_W'(NUM_HANDLES);
  endfunction

  // request latch
  func_t               func_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                rm_q;
  logic [HANDLE_W-1:0] job_q;

  // queue control
  logic [PTR_W-1:0]    head;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    scan;
  logic [CNT_W-1:0]    kept;
  logic                pend;
  logic [HIDX_W-1:0]   clr_idx;
  logic [LIMIT_W-1:0]  queue_limit;

  logic                held_ok;
  logic [HANDLE_W-1:0] held_job;

  // storage
  logic [HANDLE_W-1:0] job_mem [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] job_rdata;
  logic                busy_mem [NUM_HANDLES];
  logic                busy_rdata;

  logic                rng_q;
  logic                count_ok;
  logic                add_go;
  logic                remove_go;
  logic                get_hit;
  logic                exec_ok;
  logic                live_ok;
  logic [HANDLE_W-1:0] live_job;
  logic                purge_done;
  logic                purge_wr;
  logic                out_free;

  logic                job_we;
  logic [PTR_W-1:0]    job_waddr;
  logic [HANDLE_W-1:0] job_wdata;
  logic [PTR_W-1:0]    job_raddr;

  logic                busy_we;
  logic [HIDX_W-1:0]   busy_waddr;
  logic                busy_wdata;
  logic [HIDX_W-1:0]   busy_raddr;

  assign rng_q     = in_range(handle_q);
  assign count_ok  = (LIM_W'(count) < LIM_W'(queue_limit)) &&
                     (LIM_W'(count) < LIM_W'(QUEUE_DEPTH));
  assign add_go    = (func_q == FUNC_ADD) && rng_q && !busy_rdata && count_ok;
  assign remove_go = (func_q == FUNC_REMOVE) && rng_q && busy_rdata;
  assign get_hit   = (func_q == FUNC_GET) && (count != '0);

  always_comb begin
    case (func_q)
      FUNC_ADD:    exec_ok = add_go;
      FUNC_REMOVE: exec_ok = remove_go;
      FUNC_GET:    exec_ok = 1'b0;
      FUNC_DONE:   exec_ok = 1'b1;
      default:     exec_ok = 1'b0;
    endcase
  end

  assign live_ok  = (cmd.op == OP_CHK) ? busy_rdata : exec_ok;
  assign live_job = ((cmd.op == OP_CHK) && busy_rdata) ? job_q : '0;

  assign purge_done = (scan == count) && !pend;
  assign purge_wr   = (cmd.op == OP_PURGE) && pend && (job_rdata != handle_q);
  assign out_free   = !rsp_valid || rsp_ready;

  assign stat.clear_done = (clr_idx == HIDX_W'(NUM_HANDLES - 1));
  assign stat.get_hit    = get_hit;
  assign stat.remove_go  = remove_go;
  assign stat.purge_done = purge_done;
  assign stat.out_free   = out_free;

  // job memory ports
  always_comb begin
    job_we    = 1'b0;
    job_waddr = slot_of(head, count);
    job_wdata = handle_q;
    if ((cmd.op == OP_EXEC) && add_go) begin
      job_we = 1'b1;
    end else if (purge_wr) begin
      job_we    = 1'b1;
      job_waddr = slot_of(head, kept);
      job_wdata = job_rdata;
    end
  end

  assign job_raddr = (cmd.op == OP_PURGE) ? slot_of(head, scan) : head;

  always_ff @(posedge clk) begin
    if (job_we) job_mem[job_waddr] <= job_wdata;
    job_rdata <= job_mem[job_raddr];
  end

  // busy bitmap ports
  always_comb begin
    busy_we    = 1'b0;
    busy_waddr = to_idx(handle_q);
    busy_wdata = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        busy_we    = 1'b1;
        busy_waddr = clr_idx;
      end
      OP_EXEC: begin
        busy_we    = add_go || remove_go || ((func_q == FUNC_DONE) && rng_q);
        busy_wdata = add_go;
      end
      OP_CHK: begin
        busy_we    = busy_rdata && rm_q;
        busy_waddr = to_idx(job_q);
      end
      default: busy_we = 1'b0;
    endcase
  end

  assign busy_raddr = (cmd.op == OP_EXEC) ? to_idx(job_rdata) : to_idx(req_handle);

  always_ff @(posedge clk) begin
    if (busy_we) busy_mem[busy_waddr] <= busy_wdata;
    busy_rdata <= busy_mem[busy_raddr];
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func_t'(req_func);
      handle_q <= req_handle;
      rm_q     <= req_rm;
    end
    if (cmd.op == OP_EXEC) job_q <= job_rdata;
    if ((cmd.op == OP_EXEC) || (cmd.op == OP_CHK)) begin
      held_ok  <= live_ok;
      held_job <= live_job;
    end
    if (cmd.emit) begin
      rsp_ok  <= live_ok;
      rsp_job <= live_job;
    end else if (cmd.emit_held) begin
      rsp_ok  <= held_ok;
      rsp_job <= held_job;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      count       <= '0;
      scan        <= '0;
      kept        <= '0;
      pend        <= 1'b0;
      clr_idx     <= '0;
      queue_limit <= LIMIT_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) queue_limit <= cfg_wdata;

      if (cmd.op == OP_CLEAR) clr_idx <= clr_idx + HIDX_W'(1);

      case (cmd.op)
        OP_EXEC: begin
          scan <= '0;
          kept <= '0;
          pend <= 1'b0;
          if (add_go) begin
            count <= count + CNT_W'(1);
          end else if (get_hit) begin
            head  <= slot_of(head, CNT_W'(1));
            count <= count - CNT_W'(1);
          end
        end
        OP_PURGE: begin
          pend <= (scan != count);
          if (scan != count) scan <= scan + CNT_W'(1);
          if (purge_wr) kept <= kept + CNT_W'(1);
          if (purge_done) count <= kept;
        end
        default: pend <= 1'b0;
      endcase

      if (cmd.emit || cmd.emit_held) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(count) <= CNT_W'(QUEUE_DEPTH)) && (SUM_W'(head) < SUM_W'(QUEUE_DEPTH)))
    else $error("queue occupancy or head out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_held) |-> out_free)
    else $error("result register overwritten while full");

  a_purge_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PURGE) |-> ((kept <= scan) && (scan <= count)))
    else $error("compaction write overtook read");
`endif

endmodule

// ===== sv/dedup_job_queue_with_busy_set_top.sv =====
// Channel   Dir  Payload                          Transaction when
// job_req   in   func, handle, remove_on_get      job_req.valid && job_req.ready
// job_rsp   out  ok, job_handle                   job_rsp.valid && job_rsp.ready
// cfg       in   cfg_wdata (queue_limit)          cfg_we
//
// Steps: add, done, get on an empty queue and remove of an idle handle are accept then
// execute; get on a non-empty queue adds a step (FIFO read, then bitmap read at the head handle);
// remove of a busy handle adds a compaction pass over every queued entry in the job
// memory. One transaction is in flight at a time.
// Reset (rst, synchronous) runs a bitmap clear over all NUM_HANDLES entries, job_req.ready low.
// A finished result stalls only while the output register still holds the previous one.
module dedup_job_queue_with_busy_set_top #(
  parameter int QUEUE_DEPTH = djq_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_HANDLES = djq_pkg::NUM_HANDLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [djq_pkg::LIMIT_W-1:0] cfg_wdata,
  djq_in_if.sink                      job_req,
  djq_out_if.source                   job_rsp
);
  import djq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller sequences each request: accept, execute, optional
  // bitmap check (get) or compaction (remove), then result hand-off.
  djq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (job_req.valid),
    .in_ready (job_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the job memory, busy bitmap, pointers and result register.
  djq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_HANDLES (NUM_HANDLES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_func   (job_req.func),
    .req_handle (job_req.handle),
    .req_rm     (job_req.remove_on_get),
    .rsp_valid  (job_rsp.valid),
    .rsp_ready  (job_rsp.ready),
    .rsp_ok     (job_rsp.ok),
    .rsp_job    (job_rsp.job_handle)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import djq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int HANDLES = NUM_HANDLES_DEF;

  typedef struct packed {
    func_t               func;
    logic [HANDLE_W-1:0] handle;
    logic                remove_on_get;
  } job_req_t;

  typedef struct packed {
    logic                ok;
    logic [HANDLE_W-1:0] job_handle;
  } job_rsp_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  djq_in_if  job_req_if();
  djq_out_if job_rsp_if();

  dedup_job_queue_with_busy_set_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .job_req  (job_req_if),
    .job_rsp  (job_rsp_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue, the busy bitmap and the limit register.
  logic [HANDLE_W-1:0] shadow_fifo [DEPTH];
  bit                  shadow_busy [HANDLES];
  int                  shadow_head;
  int                  shadow_count;
  int                  shadow_limit;

  job_req_t job_backlog[$];   // transactions waiting to be driven
  job_rsp_t rsp_expected[$];  // predicted responses, oldest first
  job_req_t job_on_bus;

  bit bursts_on;
  int send_gap;
  int recv_stall;
  int mismatch_cnt;
  int checked_cnt;
  int ok_cnt;
  int func_cnt [4];
  int limit_settings;

  // Predict the response to one job request and update the shadow state.
  // Every 10-bit handle is below the handle count, so no range check applies.
  task automatic apply_job_op(input job_req_t j, output job_rsp_t r);
    logic [HANDLE_W-1:0] kept[$];
    logic [HANDLE_W-1:0] front;
    int                  lim;
    r   = '0;
    lim = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
    case (j.func)
      FUNC_ADD: begin
        if (!shadow_busy[j.handle] && shadow_count < lim) begin
          shadow_fifo[(shadow_head + shadow_count) % DEPTH] = j.handle;
          shadow_count++;
          shadow_busy[j.handle] = 1'b1;
          r.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        // compaction drops every copy of the handle, order of the rest kept
        if (shadow_busy[j.handle]) begin
          shadow_busy[j.handle] = 1'b0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_fifo[(shadow_head + i) % DEPTH] != j.handle)
              kept.push_back(shadow_fifo[(shadow_head + i) % DEPTH]);
          end
          foreach (kept[i]) shadow_fifo[(shadow_head + i) % DEPTH] = kept[i];
          shadow_count = kept.size();
          r.ok = 1'b1;
        end
      end
      FUNC_GET: begin
        // a head whose bit is clear is dropped without being returned
        if (shadow_count > 0) begin
          front       = shadow_fifo[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          if (shadow_busy[front]) begin
            if (j.remove_on_get) shadow_busy[front] = 1'b0;
            r.ok         = 1'b1;
            r.job_handle = front;
          end
        end
      end
      default: begin
        shadow_busy[j.handle] = 1'b0;
        r.ok = 1'b1;
      end
    endcase
  endtask

  task automatic post_job(input func_t f, input logic [HANDLE_W-1:0] h,
                          input logic rog);
    job_req_t j;
    j.func          = f;
    j.handle        = h;
    j.remove_on_get = rog;
    job_backlog.push_back(j);
  endtask

  // Mostly a small pool so adds, removes and dones collide; a slice near the
  // top of the range; the rest anywhere so every handle bit toggles.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return HANDLE_W'($urandom_range(0, 71));
    else if (sel < 15) return HANDLE_W'(HANDLES - 1 - $urandom_range(0, 15));
    else return HANDLE_W'($urandom_range(0, HANDLES - 1));
  endfunction

  task automatic post_random_job(input int add_pct);
    int k;
    if ($urandom_range(0, 99) < add_pct) begin
      post_job(FUNC_ADD, pick_handle(), 1'($urandom_range(0, 1)));
    end else begin
      k = $urandom_range(0, 19);
      if (k < 8) post_job(FUNC_GET, pick_handle(), 1'($urandom_range(0, 1)));
      else if (k < 13) post_job(FUNC_REMOVE, pick_handle(), 1'($urandom_range(0, 1)));
      else post_job(FUNC_DONE, pick_handle(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Hold off until every queued transaction went out and every response
  // came back; the block is idle then. Checked between edges so the
  // driver's and monitor's updates at the edge have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (job_backlog.size() != 0 || job_req_if.valid || rsp_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_queue_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_limit = int'(v);
    limit_settings++;
  endtask

  // Request driver: predicts at the accepting edge, then either holds the
  // current transaction, opens an idle burst, or presents the next one.
  always @(posedge clk) begin : drive_req
    job_rsp_t r;
    if (rst) begin
      job_req_if.valid <= 1'b0;
      send_gap         <= 0;
    end else begin
      if (job_req_if.valid && job_req_if.ready) begin
        apply_job_op(job_on_bus, r);
        rsp_expected.push_back(r);
        func_cnt[job_on_bus.func]++;
        if (r.ok) ok_cnt++;
      end
      if (!job_req_if.valid || job_req_if.ready) begin
        if (send_gap > 0) begin
          send_gap         <= send_gap - 1;
          job_req_if.valid <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
          send_gap         <= $urandom_range(0, 18);
          job_req_if.valid <= 1'b0;
        end else if (job_backlog.size() != 0) begin
          job_on_bus                = job_backlog.pop_front();
          job_req_if.valid         <= 1'b1;
          job_req_if.func          <= job_on_bus.func;
          job_req_if.handle        <= job_on_bus.handle;
          job_req_if.remove_on_get <= job_on_bus.remove_on_get;
        end else begin
          job_req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random backpressure bursts.
  always @(posedge clk) begin : watch_rsp
    job_rsp_t want;
    if (rst) begin
      job_rsp_if.ready <= 1'b0;
      recv_stall       <= 0;
    end else begin
      if (job_rsp_if.valid && job_rsp_if.ready) begin
        if (rsp_expected.size() == 0) begin
          $error("response with nothing pending: ok=%0b job_handle=%0d",
                 job_rsp_if.ok, job_rsp_if.job_handle);
          mismatch_cnt++;
        end else begin
          want = rsp_expected.pop_front();
          checked_cnt++;
          if (job_rsp_if.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, job_rsp_if.ok);
            mismatch_cnt++;
          end
          if (job_rsp_if.job_handle !== want.job_handle) begin
            $error("job_handle: expected %0d, got %0d",
                   want.job_handle, job_rsp_if.job_handle);
            mismatch_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall       <= recv_stall - 1;
        job_rsp_if.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
        recv_stall       <= $urandom_range(0, 18);
        job_rsp_if.ready <= 1'b0;
      end else begin
        job_rsp_if.ready <= 1'b1;
      end
    end
  end

  // Limit per random phase: zero, one, above the depth, exactly the depth,
  // a value just above it, and a few small ones so the queue sits full.
  localparam int NUM_PHASES = 12;
  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{
    7'd0, 7'd1, 7'd127, 7'd64, 7'd3, 7'd100, 7'd2, 7'd64, 7'd17, 7'd65, 7'd8, 7'd64
  };

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    job_req_if.valid         = 1'b0;
    job_req_if.func          = FUNC_ADD;
    job_req_if.handle        = '0;
    job_req_if.remove_on_get = 1'b0;
    job_rsp_if.ready         = 1'b0;
    bursts_on                = 1'b1;
    shadow_head              = 0;
    shadow_count             = 0;
    shadow_limit             = int'(LIMIT_RESET);
    foreach (shadow_busy[i]) shadow_busy[i] = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset limit; the bitmap clear sweep runs first
    // and the driver just waits on ready.
    post_job(FUNC_ADD,    10'd0,    1'b0);
    post_job(FUNC_ADD,    10'd1023, 1'b1);
    post_job(FUNC_ADD,    10'd0,    1'b0);   // already busy
    post_job(FUNC_REMOVE, 10'd5,    1'b0);   // not busy
    post_job(FUNC_REMOVE, 10'd1023, 1'b1);
    post_job(FUNC_GET,    10'd0,    1'b0);   // returns 0, stays busy
    post_job(FUNC_ADD,    10'd0,    1'b0);   // still busy
    post_job(FUNC_DONE,   10'd0,    1'b1);
    post_job(FUNC_DONE,   10'd0,    1'b0);   // bit already clear
    post_job(FUNC_ADD,    10'd0,    1'b1);
    post_job(FUNC_ADD,    10'd682,  1'b0);
    post_job(FUNC_DONE,   10'd682,  1'b0);
    post_job(FUNC_GET,    10'd1023, 1'b1);   // returns 0 and frees it
    post_job(FUNC_GET,    10'd0,    1'b0);   // head bit clear: dropped
    post_job(FUNC_GET,    10'd0,    1'b1);   // empty
    post_job(FUNC_ADD,    10'd341,  1'b0);
    post_job(FUNC_DONE,   10'd341,  1'b0);
    post_job(FUNC_ADD,    10'd341,  1'b1);   // second copy in the queue
    post_job(FUNC_REMOVE, 10'd341,  1'b0);   // purges both copies
    post_job(FUNC_GET,    10'd1023, 1'b0);   // empty again
    post_job(FUNC_ADD,    10'd1023, 1'b0);

    // Random phases. Each boundary drains every pending response before the
    // limit changes, so the sender fully pauses there; queue contents carry
    // over, which also covers a limit dropped below the current count.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_queue_limit(PHASE_LIMIT[p]);
      bursts_on = (p == NUM_PHASES - 1) ? 1'b0 : (p % 3 != 2);
      for (int n = 0; n < 85; n++) post_random_job((p % 3 == 1) ? 25 : 62);
    end

    wait_drained();
    repeat (100) @(posedge clk);

    if (rsp_expected.size() != 0) begin
      $error("%0d responses never arrived", rsp_expected.size());
      mismatch_cnt++;
    end

    $display("Checked %0d responses: %0d add, %0d remove, %0d get, %0d done, %0d with ok set.",
             checked_cnt, func_cnt[FUNC_ADD], func_cnt[FUNC_REMOVE], func_cnt[FUNC_GET],
             func_cnt[FUNC_DONE], ok_cnt);
    $display("queue_limit took %0d settings including 0, 1, 64 and 127.", limit_settings);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
